/* rtl/assert_macros.svh */
// Assertion macros shared by the line pixel generator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lpg_pkg.sv */
// Package for the line pixel generator: widths, command and direction codes,
// and the command record passed from front to back. No dependencies.
`timescale 1ns / 1ps

package lpg_pkg;

   localparam int COORD_BITS    = 16;
   localparam int FIELD_BITS    = 16;
   localparam int ERR_BITS      = COORD_BITS + 2;
   localparam int LEFT_BITS     = COORD_BITS + 1;
   localparam int START_EXTRA   = 2;
   localparam int REQ_DATA_BITS = 5 * FIELD_BITS;
   localparam int RSP_DATA_BITS = 3 * FIELD_BITS;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CMD_START   = 1'b0,
      CMD_ADVANCE = 1'b1
   } cmd_kind_type;

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_PLUS  = 2'd1,
      DIR_MINUS = 2'd3
   } dir_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] abs_dx;
      logic [COORD_BITS-1:0] abs_dy;
      logic [COORD_BITS-1:0] major_len;
      dir_type               col_dir;
      dir_type               row_dir;
      logic [FIELD_BITS-1:0] color;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

endpackage

/* rtl/line_pixel_generator.sv */
// Top level of the line pixel generator: front end, command queue, back end.
// Uses lpg_pkg, lpg_front, lpg_cmd_queue and lpg_back.
//
//   channel   dir   tdata (low bit up)                          tuser / tlast
//   req_      in    x_start, y_start, x_end, y_end, pen_color   tuser = mode
//   rsp_      out   pixel_x, pixel_y, pixel_color               tlast = last
//
// One request beat per cycle while the queue has room; each advance beat during a line gives one pixel beat.
// A pixel passes through its queue entry, then the result register, on its way out.
// The two-entry command queue lets req_ keep flowing while rsp_ stalls; req_tready
// drops only once the queue is full.
// Reset is synchronous and clears the queue, the line-busy flag and rsp_tvalid.
`timescale 1ns / 1ps

module line_pixel_generator import lpg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // x_start, y_start, x_end, y_end, pen_color
   input  logic                     req_tuser,   // mode
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // pixel_x, pixel_y, pixel_color
   output logic                     rsp_tlast    // last
);

   cmd_push_type push;
   cmd_head_type head;
   logic         queue_ready;
   logic         pop;

   lpg_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_ready (queue_ready),
      .push        (push)
   );

   lpg_cmd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_ready (queue_ready),
      .head        (head),
      .pop         (pop)
   );

   lpg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/lpg_front.sv */
// Front end: accepts request beats, classifies start and advance commands
// and works out deltas, directions and major length. Uses lpg_pkg.
`timescale 1ns / 1ps

module lpg_front import lpg_pkg::*; (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // x_start, y_start, x_end, y_end, pen_color
   input  logic                     req_tuser,   // mode
   input  logic                     queue_ready,
   output cmd_push_type             push
);

   typedef struct packed {
      logic [COORD_BITS-1:0] absd;
      dir_type               dir;
   } axis_type;

   function automatic axis_type axis_setup(input logic [COORD_BITS-1:0] from_pos,
                                           input logic [COORD_BITS-1:0] to_pos);
      axis_type res;
      if (to_pos > from_pos) begin
         res.absd = to_pos - from_pos;
         res.dir  = DIR_PLUS;
      end else if (to_pos == from_pos) begin
         res.absd = '0;
         res.dir  = DIR_NONE;
      end else begin
         res.absd = from_pos - to_pos;
         res.dir  = DIR_MINUS;
      end
      return res;
   endfunction

   logic [COORD_BITS-1:0] xs, ys, xe, ye;
   axis_type              col_axis, row_axis;

   assign xs = req_tdata[0*FIELD_BITS +: COORD_BITS];
   assign ys = req_tdata[1*FIELD_BITS +: COORD_BITS];
   assign xe = req_tdata[2*FIELD_BITS +: COORD_BITS];
   assign ye = req_tdata[3*FIELD_BITS +: COORD_BITS];

   assign col_axis = axis_setup(xs, xe);
   assign row_axis = axis_setup(ys, ye);

   assign req_tready = queue_ready;

   always_comb begin
      push.valid         = req_tvalid && queue_ready;
      push.cmd.kind      = cmd_kind_type'(req_tuser);
      push.cmd.x         = xs;
      push.cmd.y         = ys;
      push.cmd.abs_dx    = col_axis.absd;
      push.cmd.abs_dy    = row_axis.absd;
      push.cmd.major_len = (col_axis.absd > row_axis.absd) ? col_axis.absd : row_axis.absd;
      push.cmd.col_dir   = col_axis.dir;
      push.cmd.row_dir   = row_axis.dir;
      push.cmd.color     = req_tdata[4*FIELD_BITS +: FIELD_BITS];
   end

endmodule

/* rtl/lpg_cmd_queue.sv */
// Short command queue between front and back so each side stalls on its own.
// Uses lpg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpg_cmd_queue import lpg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_push_type push,
   output logic         queue_ready,
   output cmd_head_type head,
   input  logic         pop
);

   cmd_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign queue_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign do_push     = push.valid;
   assign do_pop      = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   `ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= QCNT_BITS'(QUEUE_DEPTH), "queue count overflow")
   `ASSERT_ALWAYS(a_no_push_full, clock, reset, !(push.valid && (count_ff == QCNT_BITS'(QUEUE_DEPTH))), "push into full queue")
   `ASSERT_IMPLIES(a_full_has_head, clock, reset, !queue_ready, head.valid, "full queue without head")

endmodule

/* rtl/lpg_back.sv */
// Back end: runs the line stepper on queued commands and drives the
// result register. Uses lpg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpg_back import lpg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_head_type             head,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // pixel_x, pixel_y, pixel_color
   output logic                     rsp_tlast    // last
);

   logic                  busy_ff, busy_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0] cur_row_ff, cur_row_in;
   logic [ERR_BITS-1:0]   col_error_ff, col_error_in;
   logic [ERR_BITS-1:0]   row_error_ff, row_error_in;
   logic [COORD_BITS-1:0] abs_dx_ff, abs_dx_in;
   logic [COORD_BITS-1:0] abs_dy_ff, abs_dy_in;
   dir_type               col_dir_ff, col_dir_in;
   dir_type               row_dir_ff, row_dir_in;
   logic [COORD_BITS-1:0] major_len_ff, major_len_in;
   logic [LEFT_BITS-1:0]  pixels_left_ff, pixels_left_in;
   logic [FIELD_BITS-1:0] line_color_ff, line_color_in;
   logic [FIELD_BITS-1:0] out_x_ff, out_x_in;
   logic [FIELD_BITS-1:0] out_y_ff, out_y_in;
   logic [FIELD_BITS-1:0] out_color_ff, out_color_in;
   logic                  out_last_ff, out_last_in;

   logic                  emit, is_last;
   logic [ERR_BITS-1:0]   col_sum, row_sum, major_ext;

   function automatic logic [COORD_BITS-1:0] move_axis(input logic [COORD_BITS-1:0] pos,
                                                       input dir_type dir);
      logic [COORD_BITS-1:0] res;
      case (dir)
         DIR_PLUS:  res = pos + 1'b1;
         DIR_MINUS: res = pos - 1'b1;
         default:   res = pos;
      endcase
      return res;
   endfunction

   assign pop       = head.valid && (!out_valid_ff || rsp_tready);
   assign emit      = pop && (head.cmd.kind == CMD_ADVANCE) && busy_ff;
   assign is_last   = (pixels_left_ff <= LEFT_BITS'(1));
   assign major_ext = ERR_BITS'(major_len_ff);
   assign col_sum   = col_error_ff + ERR_BITS'(abs_dx_ff);
   assign row_sum   = row_error_ff + ERR_BITS'(abs_dy_ff);

   always_comb begin
      busy_in        = busy_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      col_error_in   = col_error_ff;
      row_error_in   = row_error_ff;
      abs_dx_in      = abs_dx_ff;
      abs_dy_in      = abs_dy_ff;
      col_dir_in     = col_dir_ff;
      row_dir_in     = row_dir_ff;
      major_len_in   = major_len_ff;
      pixels_left_in = pixels_left_ff;
      line_color_in  = line_color_ff;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_color_in   = out_color_ff;
      out_last_in    = out_last_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;

      if (pop && (head.cmd.kind == CMD_START)) begin
         busy_in        = 1'b1;
         cur_col_in     = head.cmd.x;
         cur_row_in     = head.cmd.y;
         col_error_in   = '0;
         row_error_in   = '0;
         abs_dx_in      = head.cmd.abs_dx;
         abs_dy_in      = head.cmd.abs_dy;
         col_dir_in     = head.cmd.col_dir;
         row_dir_in     = head.cmd.row_dir;
         major_len_in   = head.cmd.major_len;
         pixels_left_in = LEFT_BITS'(head.cmd.major_len) + LEFT_BITS'(START_EXTRA);
         line_color_in  = head.cmd.color;
      end else if (emit) begin
         out_valid_in = 1'b1;
         out_x_in     = FIELD_BITS'(cur_col_ff);
         out_y_in     = FIELD_BITS'(cur_row_ff);
         out_color_in = line_color_ff;
         out_last_in  = is_last;
         col_error_in = col_sum;
         row_error_in = row_sum;
         if (col_sum > major_ext) begin
            col_error_in = col_sum - major_ext;
            cur_col_in   = move_axis(cur_col_ff, col_dir_ff);
         end
         if (row_sum > major_ext) begin
            row_error_in = row_sum - major_ext;
            cur_row_in   = move_axis(cur_row_ff, row_dir_ff);
         end
         if (is_last) begin
            pixels_left_in = '0;
            busy_in        = 1'b0;
         end else begin
            pixels_left_in = pixels_left_ff - LEFT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff     <= cur_col_in;
      cur_row_ff     <= cur_row_in;
      col_error_ff   <= col_error_in;
      row_error_ff   <= row_error_in;
      abs_dx_ff      <= abs_dx_in;
      abs_dy_ff      <= abs_dy_in;
      col_dir_ff     <= col_dir_in;
      row_dir_ff     <= row_dir_in;
      major_len_ff   <= major_len_in;
      pixels_left_ff <= pixels_left_in;
      line_color_ff  <= line_color_in;
      out_x_ff       <= out_x_in;
      out_y_ff       <= out_y_in;
      out_color_ff   <= out_color_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_color_ff, out_y_ff, out_x_ff};
   assign rsp_tlast  = out_last_ff;

   `ASSERT_IMPLIES(a_busy_has_pixels, clock, reset, busy_ff, pixels_left_ff != '0, "busy with no pixels left")
   `ASSERT_IMPLIES(a_error_bounded, clock, reset, busy_ff, (col_error_ff <= major_ext) && (row_error_ff <= major_ext), "error accumulator above major length")
   `ASSERT_NEXT(a_last_ends_line, clock, reset, emit && is_last, !busy_ff && out_last_ff, "last beat did not end the line")

endmodule
